// ===== hdl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg: shared widths for the rectangle center distance block
// Field, intermediate and square root widths used by every file.
// ----------------------------------------------------------------------------
package rcd_pkg;

  // Input coordinate and size fields.
  localparam int unsigned CoordW  = 16;
  // A center lies in [-32768, 65534], so it needs 18 signed bits.
  localparam int unsigned CenterW = CoordW + 2;
  // The absolute difference of two centers is at most 98302.
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned SqW     = 2 * DiffW;
  localparam int unsigned SumW    = SqW + 1;
  // The root of a SumW-bit value, padded to an even number of bits.
  localparam int unsigned RadW    = SumW + (SumW % 2);
  localparam int unsigned RootW   = RadW / 2;
  // The partial remainder never exceeds twice the partial root.
  localparam int unsigned RemW    = RootW + 2;

endpackage

// ===== hdl/rcd_isqrt.sv =====
// ----------------------------------------------------------------------------
// rcd_isqrt: pipelined exact integer floor square root
// One result bit per stage, digit by digit, restoring form.
// ----------------------------------------------------------------------------
module rcd_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic                          valid_i,
  input  logic [rcd_pkg::SumW-1:0]      radicand_i,
  output logic                          valid_o,
  output logic [rcd_pkg::RootW-1:0]     root_o
);

  localparam int unsigned RadW  = rcd_pkg::RadW;
  localparam int unsigned RootW = rcd_pkg::RootW;
  localparam int unsigned RemW  = rcd_pkg::RemW;

  logic [RadW-1:0]  rad_q  [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic             vld_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic             vld_in;
    logic [RemW+1:0]  rem_sh;
    logic [RemW+1:0]  trial;
    logic [RemW+1:0]  diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rad_in  = RadW'(radicand_i);
      assign rem_in  = '0;
      assign root_in = '0;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4 + 1.
    always_comb begin
      rem_sh = {rem_in, rad_in[RadW-1 -: 2]};
      trial  = (RemW + 2)'({root_in, 2'b01});
      diff   = rem_sh - trial;
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (advance_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
        root_q[k] <= {root_in[RootW-2:0], ge};
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];

endmodule

// ===== hdl/rect_center_distance.sv =====
// ----------------------------------------------------------------------------
// rect_center_distance: floor distance between two rectangle centers
// Finds both centers, squares the differences and takes an exact floor root.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | input     | in_valid_i / in_stall_o | first_*, second_* (x, y, w, h)
//  out     | output    | out_valid_o/out_stall_i | center_distance_o (18 bits)
//
// One request enters every cycle unless the pipeline stalls. Its result
// passes one stage for the centers and differences, one for the two squares,
// one for their sum and one stage per result bit of the square root (18 stages).
// The whole pipeline advances together; when the result register holds a
// valid result that the receiver stalls, every stage holds and in_stall_o
// is raised, so nothing is lost or repeated. Reset clears only the valid
// bits; data registers carry no reset.
//
module rect_center_distance (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [rcd_pkg::CoordW-1:0] first_x_i,
  input  logic signed [rcd_pkg::CoordW-1:0] first_y_i,
  input  logic [rcd_pkg::CoordW-1:0]      first_width_i,
  input  logic [rcd_pkg::CoordW-1:0]      first_height_i,
  input  logic signed [rcd_pkg::CoordW-1:0] second_x_i,
  input  logic signed [rcd_pkg::CoordW-1:0] second_y_i,
  input  logic [rcd_pkg::CoordW-1:0]      second_width_i,
  input  logic [rcd_pkg::CoordW-1:0]      second_height_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rcd_pkg::RootW-1:0]       center_distance_o
);

  localparam int unsigned CenterW = rcd_pkg::CenterW;
  localparam int unsigned DiffW   = rcd_pkg::DiffW;
  localparam int unsigned SqW     = rcd_pkg::SqW;
  localparam int unsigned SumW    = rcd_pkg::SumW;

  // The pipeline moves unless a finished result is waiting on the receiver.
  logic advance;
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  // Center = edge + floor(size / 2), held in 18 signed bits.
  function automatic logic signed [CenterW-1:0] center_of(
    input logic signed [rcd_pkg::CoordW-1:0] edge_v,
    input logic [rcd_pkg::CoordW-1:0]        size_v
  );
    logic signed [CenterW-1:0] e;
    logic signed [CenterW-1:0] h;
    e = CenterW'(edge_v);
    h = signed'({3'b000, size_v[rcd_pkg::CoordW-1:1]}) ;
    return e + h;
  endfunction

  function automatic logic [DiffW-1:0] abs_diff(
    input logic signed [CenterW-1:0] a,
    input logic signed [CenterW-1:0] b
  );
    logic signed [CenterW:0] d;
    d = (a >= b) ? ((CenterW + 1)'(a) - (CenterW + 1)'(b))
                 : ((CenterW + 1)'(b) - (CenterW + 1)'(a));
    return d[DiffW-1:0];
  endfunction

  // Stage 1: centers and absolute differences.
  logic             s1_vld_q;
  logic [DiffW-1:0] dx_q, dy_q;
  logic [DiffW-1:0] dx_d, dy_d;

  always_comb begin
    dx_d = abs_diff(center_of(first_x_i, first_width_i),
                    center_of(second_x_i, second_width_i));
    dy_d = abs_diff(center_of(first_y_i, first_height_i),
                    center_of(second_y_i, second_height_i));
  end

  // Stage 2: the two squares. Stage 3: their sum, which cannot overflow.
  logic           s2_vld_q, s3_vld_q;
  logic [SqW-1:0] dx2_q, dy2_q;
  logic [SumW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      dx2_q <= dx_q * dx_q;
      dy2_q <= dy_q * dy_q;
      sum_q <= SumW'(dx2_q) + SumW'(dy2_q);
    end
  end

  // Stages 4 to 21: one root bit per stage.
  rcd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .valid_i    (s3_vld_q),
    .radicand_i (sum_q),
    .valid_o    (out_valid_o),
    .root_o     (center_distance_o)
  );

endmodule

// ===== tb/rect_center_distance_test.sv =====
// ----------------------------------------------------------------------------
// rect_center_distance_test: self-checking bench for the center distance block
// Streams rectangle pairs through the pipeline with random gaps and stalls,
// predicts each floor distance independently and compares results in order.
// ----------------------------------------------------------------------------
module rect_center_distance_test;

  localparam int unsigned CoordW = rcd_pkg::CoordW;
  localparam int unsigned RootW  = rcd_pkg::RootW;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [CoordW-1:0]        w;
    logic [CoordW-1:0]        h;
  } rect_t;

  typedef struct {
    rect_t first;
    rect_t second;
    int    gap;   // idle cycles the driver inserts after this request
  } distance_request_t;

  localparam int unsigned NumRandom = 1600;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned DrainCycles = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CoordW-1:0] first_x_i = '0;
  logic signed [CoordW-1:0] first_y_i = '0;
  logic [CoordW-1:0] first_width_i = '0;
  logic [CoordW-1:0] first_height_i = '0;
  logic signed [CoordW-1:0] second_x_i = '0;
  logic signed [CoordW-1:0] second_y_i = '0;
  logic [CoordW-1:0] second_width_i = '0;
  logic [CoordW-1:0] second_height_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [RootW-1:0] center_distance_o;

  distance_request_t pending_requests[$];
  logic [RootW-1:0]  expected_distances[$];
  distance_request_t active_request;
  int gap_left = 0;
  int stall_left = 0;
  int in_gap_max = 0;
  int out_stall_max = 0;
  int error_count = 0;

  always #5 clk_i = ~clk_i;

  rect_center_distance DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .first_x_i        (first_x_i),
    .first_y_i        (first_y_i),
    .first_width_i    (first_width_i),
    .first_height_i   (first_height_i),
    .second_x_i       (second_x_i),
    .second_y_i       (second_y_i),
    .second_width_i   (second_width_i),
    .second_height_i  (second_height_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .center_distance_o(center_distance_o)
  );

  // Center along one axis: the signed position plus half the size, rounded down.
  function automatic longint center_of(logic signed [CoordW-1:0] pos, logic [CoordW-1:0] size);
    return longint'(pos) + longint'(size >> 1);
  endfunction

  // Floor of the distance between the two centers. The root is built one bit
  // at a time from the top, keeping each bit whose square still fits the sum.
  function automatic logic [RootW-1:0] predict_distance(rect_t a, rect_t b);
    longint dx;
    longint dy;
    longint unsigned sq_sum;
    longint unsigned trial;
    logic [RootW-1:0] root;
    dx = center_of(a.x, a.w) - center_of(b.x, b.w);
    dy = center_of(a.y, a.h) - center_of(b.y, b.h);
    sq_sum = longint'(dx * dx) + longint'(dy * dy);
    root = '0;
    for (int bit_idx = RootW - 1; bit_idx >= 0; bit_idx--) begin
      trial = longint'(root) | (64'd1 << bit_idx);
      if (trial * trial <= sq_sum) begin
        root = trial[RootW-1:0];
      end
    end
    return root;
  endfunction

  function automatic rect_t make_rect(int x, int y, int w, int h);
    rect_t r;
    r.x = x[CoordW-1:0];
    r.y = y[CoordW-1:0];
    r.w = w[CoordW-1:0];
    r.h = h[CoordW-1:0];
    return r;
  endfunction

  // Mostly uniform values, with a bias toward the ends and the middle of the range.
  function automatic logic [CoordW-1:0] rand_field();
    logic [CoordW-1:0] v;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        v = CoordW'($urandom);
      end
      3: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      4: begin
        v = CoordW'($urandom_range(0, 15));
      end
      default: begin
        v = CoordW'(16'hFFF0 + $urandom_range(0, 15));
      end
    endcase
    return v;
  endfunction

  task automatic queue_request(rect_t a, rect_t b);
    distance_request_t req;
    req.first = a;
    req.second = b;
    req.gap = $urandom_range(0, in_gap_max);
    pending_requests.push_back(req);
  endtask

  // Random pair: unrelated rectangles, a Pythagorean offset that gives an exact
  // root, or a near neighbor with small deltas on every field.
  task automatic queue_random_request();
    rect_t a;
    rect_t b;
    int k;
    a = {rand_field(), rand_field(), rand_field(), rand_field()};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        b = {rand_field(), rand_field(), rand_field(), rand_field()};
      end
      5, 6, 7: begin
        k = $urandom_range(0, 2000) - 1000;
        b = a;
        if ($urandom_range(0, 1) == 1) begin
          b.x = CoordW'(a.x + 3 * k);
          b.y = CoordW'(a.y + 4 * k);
        end else begin
          b.x = CoordW'(a.x + 4 * k);
          b.y = CoordW'(a.y - 3 * k);
        end
      end
      default: begin
        b.x = CoordW'(a.x + $urandom_range(0, 6) - 3);
        b.y = CoordW'(a.y + $urandom_range(0, 6) - 3);
        b.w = CoordW'(a.w + $urandom_range(0, 6) - 3);
        b.h = CoordW'(a.h + $urandom_range(0, 6) - 3);
      end
    endcase
    queue_request(a, b);
  endtask

  // Request driver. A stalled request is held unchanged; once it is taken its
  // expected distance is recorded and the next request follows its gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        expected_distances.push_back(predict_distance(active_request.first,
                                                      active_request.second));
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        active_request = pending_requests.pop_front();
        first_x_i <= active_request.first.x;
        first_y_i <= active_request.first.y;
        first_width_i <= active_request.first.w;
        first_height_i <= active_request.first.h;
        second_x_i <= active_request.second.x;
        second_y_i <= active_request.second.y;
        second_width_i <= active_request.second.w;
        second_height_i <= active_request.second.h;
        in_valid_i <= 1'b1;
        gap_left <= active_request.gap;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor. Each accepted distance is checked against the oldest
  // expectation, then the receiver stalls for a freshly drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    int n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (expected_distances.size() == 0) begin
        $display("%0t: unexpected center_distance, expected none, got %0d",
                 $time, center_distance_o);
        error_count++;
      end else if (expected_distances[0] !== center_distance_o) begin
        $display("%0t: center_distance mismatch, expected %0d, got %0d",
                 $time, expected_distances[0], center_distance_o);
        error_count++;
        void'(expected_distances.pop_front());
      end else begin
        void'(expected_distances.pop_front());
      end
      n = $urandom_range(0, out_stall_max);
      stall_left <= n;
      out_stall_i <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs: zero sizes, odd sizes that round down, the widest spans,
    // single-axis offsets and exact or just-missed perfect squares.
    queue_request(make_rect(0, 0, 0, 0), make_rect(0, 0, 0, 0));
    queue_request(make_rect(0, 0, 0, 0), make_rect(3, 4, 0, 0));
    queue_request(make_rect(-32768, -32768, 65535, 65535),
                  make_rect(-32768, -32768, 65535, 65535));
    queue_request(make_rect(-32768, -32768, 0, 0),
                  make_rect(32767, 32767, 65535, 65535));
    queue_request(make_rect(32767, 32767, 65535, 65535),
                  make_rect(-32768, -32768, 0, 0));
    queue_request(make_rect(32767, 32767, 65535, 65535),
                  make_rect(-32768, 32767, 0, 65535));
    queue_request(make_rect(-32768, -32768, 65535, 0),
                  make_rect(-32768, 32767, 65535, 65535));
    queue_request(make_rect(0, 0, 1, 1), make_rect(0, 0, 0, 0));
    queue_request(make_rect(0, 0, 3, 3), make_rect(0, 0, 0, 0));
    queue_request(make_rect(-1, -1, 1, 1), make_rect(1, 1, 0, 0));
    queue_request(make_rect(-100, -200, 50, 60), make_rect(100, 200, 50, 60));
    queue_request(make_rect(0, 0, 0, 0), make_rect(5, 5, 0, 0));
    queue_request(make_rect(0, 0, 0, 0), make_rect(0, 0, 65535, 65535));
    queue_request(make_rect(0, 0, 0, 0), make_rect(-32768, -32768, 0, 0));
    queue_request(make_rect(32767, -32768, 65534, 0),
                  make_rect(-32768, 32767, 1, 65535));
    queue_request(make_rect(-32768, 32767, 65535, 65534),
                  make_rect(32767, -32768, 65534, 65535));
    queue_request(make_rect(10, 10, 6, 8), make_rect(10, 10, 7, 9));
    queue_request(make_rect(-5, 7, 0, 0), make_rect(-5, 7, 0, 0));

    // Random phases alternate full-rate streaming with gaps on either side.
    for (int phase = 0; phase < NumPhases; phase++) begin
      while (pending_requests.size() != 0) @(posedge clk_i);
      in_gap_max = (phase % 4 == 0 || phase % 4 == 2) ? 0 : 7;
      out_stall_max = (phase % 4 == 0 || phase % 4 == 1) ? 0 : 7;
      for (int i = 0; i < NumRandom / NumPhases; i++) begin
        queue_random_request();
      end
    end

    while (pending_requests.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_distances.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0 && expected_distances.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of the full stimulus.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rcd_pkg.sv
hdl/rcd_isqrt.sv
hdl/rect_center_distance.sv
tb/rect_center_distance_test.sv
